### rtl/a51_pkg.sv
// Shared types and constants for the A5/1 keystream unit.
`timescale 1ns / 1ps

package a51_pkg;

  // Register lengths
  localparam int unsigned XLen = 19;
  localparam int unsigned YLen = 22;
  localparam int unsigned ZLen = 23;
  localparam int unsigned KeyW = XLen + YLen + ZLen;

  // Clocking bit positions
  localparam int unsigned XClk = 8;
  localparam int unsigned YClk = 10;
  localparam int unsigned ZClk = 10;

  // Steps per byte
  localparam int unsigned ByteW = 8;

  // State of the three shift registers
  typedef struct packed {
    logic [ZLen-1:0] z;
    logic [YLen-1:0] y;
    logic [XLen-1:0] x;
  } lfsr_state_t;

endpackage

### rtl/a51_step.sv
// One majority-clocked step of the three A5/1 shift registers.
`timescale 1ns / 1ps

module a51_step (
  input  a51_pkg::lfsr_state_t state_i,
  output a51_pkg::lfsr_state_t state_o,
  output logic                 ks_bit_o
);

  logic cx, cy, cz, maj;
  logic fb_x, fb_y, fb_z;

  // Clock bits and their majority
  assign cx  = state_i.x[a51_pkg::XClk];
  assign cy  = state_i.y[a51_pkg::YClk];
  assign cz  = state_i.z[a51_pkg::ZClk];
  assign maj = (cx & cy) | (cx & cz) | (cy & cz);

  // Feedback taps
  assign fb_x = state_i.x[13] ^ state_i.x[16] ^ state_i.x[17] ^ state_i.x[18];
  assign fb_y = state_i.y[20] ^ state_i.y[21];
  assign fb_z = state_i.z[7] ^ state_i.z[20] ^ state_i.z[21] ^ state_i.z[22];

  // Each register steps when its clock bit agrees with the majority
  always_comb begin
    state_o = state_i;
    if (cx == maj) begin
      state_o.x = {state_i.x[a51_pkg::XLen-2:0], fb_x};
    end
    if (cy == maj) begin
      state_o.y = {state_i.y[a51_pkg::YLen-2:0], fb_y};
    end
    if (cz == maj) begin
      state_o.z = {state_i.z[a51_pkg::ZLen-2:0], fb_z};
    end
  end

  // Keystream bit from the top bits after the step
  assign ks_bit_o = state_o.x[a51_pkg::XLen-1] ^ state_o.y[a51_pkg::YLen-1]
                  ^ state_o.z[a51_pkg::ZLen-1];

endmodule

### rtl/a51_keystream.sv
// Chain of eight steps producing one keystream byte, first bit at the MSB.
`timescale 1ns / 1ps

module a51_keystream (
  input  a51_pkg::lfsr_state_t          state_i,
  output a51_pkg::lfsr_state_t          state_o,
  output logic [a51_pkg::ByteW-1:0]     ks_byte_o
);

  a51_pkg::lfsr_state_t chain [a51_pkg::ByteW+1];

  assign chain[0] = state_i;

  for (genvar g = 0; g < a51_pkg::ByteW; g++) begin : g_step
    a51_step u_step (
      .state_i  (chain[g]),
      .state_o  (chain[g+1]),
      .ks_bit_o (ks_byte_o[a51_pkg::ByteW-1-g])
    );
  end

  assign state_o = chain[a51_pkg::ByteW];

endmodule

### rtl/a5_1_stream_cipher_unit.sv
// Top level of the A5/1 byte stream cipher unit.
`timescale 1ns / 1ps

// Each accepted item is one byte. It is XORed with eight keystream bits
// (first bit at the MSB) and comes out as one result item. The unit takes
// one byte per cycle unless the result side stalls. An input register
// feeds eight chained majority steps; when it fires, they advance the
// registers and load the result register. A byte whose tuser flag is set
// starts a message: the registers are first reloaded from the key (key
// bits 0..18 to X, 19..40 to Y, 41..63 to Z). The user must write the key
// through key_we_i/key_wdata_i only while no byte is in flight; the block
// itself does not enforce it. The key takes effect at the next message
// start. Encryption and decryption are the same operation.
module a5_1_stream_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // key register
  input  logic                        key_we_i,
  input  logic [a51_pkg::KeyW-1:0]    key_wdata_i,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tuser,   // [0] message_start
  // output stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata    // [7:0] result_byte
);

  logic [a51_pkg::KeyW-1:0] key_q;
  a51_pkg::lfsr_state_t     lfsr_q, lfsr_d, start_state;
  logic                     in_valid_q;
  logic [7:0]               in_data_q;
  logic                     in_start_q;
  logic                     out_valid_q;
  logic [7:0]               out_data_q;
  logic [7:0]               ks_byte;
  logic                     fire;
  logic                     s_accept;

  // Handshake: compute when the result register is free or draining
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (key_we_i) begin
      key_q <= key_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_data_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // Start from the key at a message start, else from the running state
  always_comb begin
    start_state = lfsr_q;
    if (in_start_q) begin
      start_state.x = key_q[a51_pkg::XLen-1:0];
      start_state.y = key_q[a51_pkg::XLen+a51_pkg::YLen-1:a51_pkg::XLen];
      start_state.z = key_q[a51_pkg::KeyW-1:a51_pkg::XLen+a51_pkg::YLen];
    end
  end

  a51_keystream u_keystream (
    .state_i   (start_state),
    .state_o   (lfsr_d),
    .ks_byte_o (ks_byte)
  );

  // Shift register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= '0;
    end else if (fire) begin
      lfsr_q <= lfsr_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= in_data_q ^ ks_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("computed item did not reach the result register");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(lfsr_q))
    else $error("register state moved without an item");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are blocked");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input register refuses an item");

endmodule

### tb/tb_a5_1_stream_cipher_unit.sv
// Self-checking testbench for the A5/1 byte stream cipher unit.
`timescale 1ns / 1ps

module tb_a5_1_stream_cipher_unit;

  localparam int unsigned RandItems = 650;   // random part, on top of the directed items
  localparam int unsigned StallLen  = 150;   // long output hold-off, in cycles
  localparam int unsigned WdogLimit = 2000;  // cycles with no item moving on either side
  localparam int unsigned SettleCyc = 4;     // idle wait after the last expected result is drained

  // DUT ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     key_we_i = 1'b0;
  logic [a51_pkg::KeyW-1:0] key_wdata_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;   // [7:0] data_byte
  logic                     s_axis_tuser = 1'b0; // [0] message_start
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [7:0]               m_axis_tdata;        // [7:0] result_byte

  // cipher shadow state
  logic [a51_pkg::KeyW-1:0] key_shadow = '0;
  logic [a51_pkg::XLen-1:0] shadow_x = '0;
  logic [a51_pkg::YLen-1:0] shadow_y = '0;
  logic [a51_pkg::ZLen-1:0] shadow_z = '0;

  logic [7:0] expected_bytes[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          gaps_on = 1'b0;
  bit          hold_req = 1'b0;

  a5_1_stream_cipher_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .key_we_i      (key_we_i),
    .key_wdata_i   (key_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the shadow registers by one byte and return the ciphered byte
  function automatic logic [7:0] keystream_xor(input logic [7:0] din, input logic start);
    logic [7:0] ks;
    logic       cx, cy, cz, maj;
    ks = '0;
    if (start) begin
      shadow_x = key_shadow[a51_pkg::XLen-1:0];
      shadow_y = key_shadow[a51_pkg::XLen +: a51_pkg::YLen];
      shadow_z = key_shadow[a51_pkg::XLen+a51_pkg::YLen +: a51_pkg::ZLen];
    end
    for (int i = 0; i < a51_pkg::ByteW; i++) begin
      cx  = shadow_x[a51_pkg::XClk];
      cy  = shadow_y[a51_pkg::YClk];
      cz  = shadow_z[a51_pkg::ZClk];
      maj = (cx & cy) | (cx & cz) | (cy & cz);
      // taps: X 13,16,17,18; Y 20,21; Z 7,20,21,22
      if (cx == maj)
        shadow_x = {shadow_x[a51_pkg::XLen-2:0],
                    shadow_x[13] ^ shadow_x[16] ^ shadow_x[17] ^ shadow_x[18]};
      if (cy == maj)
        shadow_y = {shadow_y[a51_pkg::YLen-2:0], shadow_y[20] ^ shadow_y[21]};
      if (cz == maj)
        shadow_z = {shadow_z[a51_pkg::ZLen-2:0],
                    shadow_z[7] ^ shadow_z[20] ^ shadow_z[21] ^ shadow_z[22]};
      ks = {ks[6:0], shadow_x[a51_pkg::XLen-1] ^ shadow_y[a51_pkg::YLen-1]
                     ^ shadow_z[a51_pkg::ZLen-1]};
    end
    return din ^ ks;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s", $realtime, what);
  endtask

  // Output side: check each result, then pick next tready
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0)
        note_mismatch($sformatf("unexpected result_byte %02h", m_axis_tdata));
      else if (m_axis_tdata !== expected_bytes[0])
        note_mismatch($sformatf("result_byte expected %02h got %02h",
                                expected_bytes[0], m_axis_tdata));
      if (expected_bytes.size() != 0)
        void'(expected_bytes.pop_front());
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = StallLen;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 9);
    end
  end

  // Watchdog on cycles where no item moves
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WdogLimit) begin
      $display("%0t ns: watchdog, %0d results outstanding", $realtime, expected_bytes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one item and wait for it to be taken; last drops tvalid afterwards
  task automatic send_byte(input logic [7:0] data, input logic start, input logic last);
    int unsigned gap;
    if (gaps_on && $urandom_range(99) < 9) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= start;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_bytes.push_back(keystream_xor(data, start));
    items_sent++;
    if (last)
      s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Key write, only while nothing is in flight
  task automatic write_key(input logic [a51_pkg::KeyW-1:0] value);
    key_we_i    <= 1'b1;
    key_wdata_i <= value;
    key_shadow = value;
    @(posedge clk_i);
    key_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [a51_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'hAAAA_AAAA_AAAA_AAAA;
      3: return 64'h5555_5555_5555_5555;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Before any message start the registers are zero: bytes pass unchanged
  task automatic test_passthrough();
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
    wait_drain();
  endtask

  // Short messages under extreme and sparse keys
  task automatic test_key_extremes();
    logic [a51_pkg::KeyW-1:0] keys[5];
    keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 64'h8000_0000_0000_0000,
             64'hAAAA_AAAA_AAAA_AAAA};
    foreach (keys[k]) begin
      write_key(keys[k]);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0);
      send_byte(8'($urandom), 1'b0, 1'b1);
      wait_drain();
    end
  endtask

  // A key written mid-message waits for the next message start
  task automatic test_key_midmessage();
    write_key(64'h0123_4567_89AB_CDEF);
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);
    wait_drain();
    write_key(64'hFEDC_BA98_7654_3210);
    send_byte(8'h96, 1'b0, 1'b0);
    send_byte(8'h69, 1'b0, 1'b0);
    send_byte(8'h81, 1'b1, 1'b1);
    wait_drain();
  endtask

  // Long output hold-off while input keeps coming, so the unit stalls its input
  task automatic test_output_stall();
    write_key(pick_key());
    gaps_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++)
      send_byte(8'($urandom), i == 0, i == 39);
    wait_drain();
  endtask

  // Random messages, with key changes between some of them
  task automatic test_random_messages();
    int unsigned first, len;
    bit          rekey, rekey_next, stray;
    first = items_sent;
    rekey = 1'b1;
    while (items_sent - first < RandItems) begin
      if (rekey) begin
        wait_drain();
        write_key(pick_key());
      end
      // opening stretch without gaps, then mostly gappy messages
      gaps_on = (items_sent - first >= 150) && ($urandom_range(4) != 0);
      len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      // a few messages lack their start byte and just continue the stream
      stray = ($urandom_range(9) == 0);
      rekey_next = ($urandom_range(3) == 0) || (items_sent - first + len >= RandItems);
      for (int i = 0; i < len; i++)
        send_byte(8'($urandom), (i == 0 && !stray) || ($urandom_range(63) == 0),
                  (i == len - 1) && rekey_next);
      rekey = rekey_next;
    end
    wait_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_key_extremes();
    test_key_midmessage();
    test_output_stall();
    test_random_messages();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_bytes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/a51_pkg.sv
rtl/a51_step.sv
rtl/a51_keystream.sv
rtl/a5_1_stream_cipher_unit.sv
tb/tb_a5_1_stream_cipher_unit.sv
